[rtl/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// cmf_pkg: shared definitions for the complex binary matched filter
// Widths, register indexes, reset patterns and the per-cell coefficient type.
// ----------------------------------------------------------------------------
`default_nettype none

package cmf_pkg;

  // default parameter values
  localparam int DEF_TAPS        = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed field widths
  localparam int OUT_W        = 23;
  localparam int PATTERN_BITS = 32;
  localparam int CFG_IDX_W    = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_I_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PATTERN = 1'd1;

  // pattern values after reset
  localparam logic [PATTERN_BITS-1:0] RESET_I_PATTERN = 32'd486037701;
  localparam logic [PATTERN_BITS-1:0] RESET_Q_PATTERN = 32'd3617957972;

  // sign bits that one tap sees (1 adds, 0 subtracts)
  typedef struct packed {
    logic i_bit;
    logic q_bit;
  } coef_t;

endpackage

`default_nettype wire

[rtl/cmf_cell.sv]
// ----------------------------------------------------------------------------
// cmf_cell: one tap of the matched filter chain
// Holds one I and one Q sample, shifts them to the next cell on advance and
// adds its signed contribution to the partial sums walking down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cmf_cell
  import cmf_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int ACC_W       = 24
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           shift_en,
  input  coef_t                         coef,
  input  wire signed [SAMPLE_BITS-1:0]  tap_i_in,
  input  wire signed [SAMPLE_BITS-1:0]  tap_q_in,
  output logic signed [SAMPLE_BITS-1:0] tap_i_out,
  output logic signed [SAMPLE_BITS-1:0] tap_q_out,
  input  wire signed [ACC_W-1:0]        psum_x_in,
  input  wire signed [ACC_W-1:0]        psum_y_in,
  output logic signed [ACC_W-1:0]       psum_x_out,
  output logic signed [ACC_W-1:0]       psum_y_out
);

  logic signed [SAMPLE_BITS-1:0] tap_i_r, tap_q_r;
  logic signed [ACC_W-1:0]       psum_x_r, psum_y_r;
  logic signed [ACC_W-1:0]       psum_x_nxt, psum_y_nxt;
  logic signed [ACC_W-1:0]       i_ext, q_ext;
  logic signed [ACC_W-1:0]       i_by_ci, q_by_cq, q_by_ci, i_by_cq;

  // tap storage, shifted toward the older end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_i_r <= '0;
      tap_q_r <= '0;
    end else if (shift_en) begin
      tap_i_r <= tap_i_in;
      tap_q_r <= tap_q_in;
    end
  end

  // signed contributions of this tap
  always_comb begin
    i_ext      = ACC_W'(tap_i_r);
    q_ext      = ACC_W'(tap_q_r);
    i_by_ci    = coef.i_bit ? i_ext : -i_ext;
    q_by_cq    = coef.q_bit ? q_ext : -q_ext;
    q_by_ci    = coef.i_bit ? q_ext : -q_ext;
    i_by_cq    = coef.q_bit ? i_ext : -i_ext;
    psum_x_nxt = psum_x_in + i_by_ci + q_by_cq;
    psum_y_nxt = psum_y_in + q_by_ci - i_by_cq;
  end

  // partial sum register, one cell per cycle
  always_ff @(posedge clk) begin
    psum_x_r <= psum_x_nxt;
    psum_y_r <= psum_y_nxt;
  end

  assign tap_i_out  = tap_i_r;
  assign tap_q_out  = tap_q_r;
  assign psum_x_out = psum_x_r;
  assign psum_y_out = psum_y_r;

endmodule

`default_nettype wire

[rtl/complex_binary_matched_filter_top.sv]
// ----------------------------------------------------------------------------
// complex_binary_matched_filter_top: complex BPSK matched filter correlator
// I/Q delay lines correlated against two programmable sign patterns.
// ----------------------------------------------------------------------------
// One item is worked on at a time. After an input transfer the result is
// offered once the sums reach the chain end, and the next input is taken
// in the cycle after that result has been transferred. The wait comes from
// the partial sums, which walk down the row of tap cells one cell per clock.
// The sign patterns are to be written through the cfg port only while the
// block is idle, which the block itself does not enforce; index 0 is the I
// pattern, index 1 the Q pattern. Taps past bit 31 subtract.
// Outputs are x = II + QQ and y = QI - IQ, kept to 23 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_binary_matched_filter_top
  import cmf_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [SAMPLE_BITS-1:0] in_sample_i,
  input  wire signed [SAMPLE_BITS-1:0] in_sample_q,
  input  wire                          in_advance,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [OUT_W-1:0]      out_x_out,
  output logic signed [OUT_W-1:0]      out_y_out,
  // configuration channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [CFG_IDX_W-1:0]          cfg_index,
  input  wire [PATTERN_BITS-1:0]       cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(TAPS) + 2;
  localparam int ACC_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int CNT_W = $clog2(TAPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PATTERN_BITS-1:0] i_pat_r, q_pat_r;
  logic                    in_xfer, shift_en;

  logic signed [SAMPLE_BITS-1:0] tap_i_chain [TAPS+1];
  logic signed [SAMPLE_BITS-1:0] tap_q_chain [TAPS+1];
  logic signed [ACC_W-1:0]       psum_x_chain [TAPS+1];
  logic signed [ACC_W-1:0]       psum_y_chain [TAPS+1];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_pat_r <= RESET_I_PATTERN;
      q_pat_r <= RESET_Q_PATTERN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_I_PATTERN: i_pat_r <= cfg_data;
        REG_Q_PATTERN: q_pat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign in_xfer   = in_valid & in_ready;
  assign shift_en  = in_xfer & in_advance;

  // sequencer: wait for the sums to reach the end of the chain
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // chain heads
  assign tap_i_chain[0]  = in_sample_i;
  assign tap_q_chain[0]  = in_sample_q;
  assign psum_x_chain[0] = '0;
  assign psum_y_chain[0] = '0;

  // row of tap cells
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    coef_t coef;

    if (k < PATTERN_BITS) begin : g_coef
      assign coef.i_bit = i_pat_r[k];
      assign coef.q_bit = q_pat_r[k];
    end else begin : g_zero
      assign coef = '0;
    end

    cmf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .coef       (coef),
      .tap_i_in   (tap_i_chain[k]),
      .tap_q_in   (tap_q_chain[k]),
      .tap_i_out  (tap_i_chain[k+1]),
      .tap_q_out  (tap_q_chain[k+1]),
      .psum_x_in  (psum_x_chain[k]),
      .psum_y_in  (psum_y_chain[k]),
      .psum_x_out (psum_x_chain[k+1]),
      .psum_y_out (psum_y_chain[k+1])
    );
  end

  // result is held at the chain end while taps and patterns stay still
  assign out_x_out = psum_x_chain[TAPS][OUT_W-1:0];
  assign out_y_out = psum_y_chain[TAPS][OUT_W-1:0];

endmodule

`default_nettype wire
